FILE: src/ycb_pkg.sv
`timescale 1ns / 1ps

package ycb_pkg;

    typedef struct packed {
        logic [7:0]  year_offset;
        logic [24:0] seconds_in_year;
    } ycb_in_t;

    typedef struct packed {
        logic [15:0] year_bcd;
        logic [7:0]  month_bcd;
        logic [7:0]  day_bcd;
        logic [7:0]  hour_bcd;
        logic [7:0]  minute_bcd;
        logic [7:0]  second_bcd;
        logic        out_of_range;
    } ycb_out_t;

    localparam logic [11:0] EPOCH_RESET = 12'd1970;

    localparam logic [25:0] DAY_SECS  = 26'd86400;
    localparam logic [8:0]  YEAR_DAYS = 9'd365;

    // floor(x / d) as (x * M) >> K, exact over the stated input width
    localparam logic [18:0] RCP_DAY  = 19'd397683; // /675,  18-bit x, K = 28
    localparam logic [15:0] RCP_MIN  = 16'd34953;  // /15,   15-bit x, K = 19
    localparam logic [9:0]  RCP_HOUR = 10'd547;    // /15,    9-bit x, K = 13
    localparam logic [10:0] RCP_THOU = 11'd1049;   // /125,  10-bit x, K = 17
    localparam logic [8:0]  RCP_HUND = 9'd328;     // /25,    8-bit x, K = 13
    localparam logic [14:0] RCP_TEN  = 15'd205;    // /10,    7-bit x, K = 11

    // days before each month in a common year, last entry is the year length
    localparam logic [8:0] MONTH_START [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // two bcd digits of a value below 100
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * RCP_TEN;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

FILE: src/ycb_pipe.sv
`timescale 1ns / 1ps

module ycb_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ycb_pkg::ycb_in_t request,
    input  logic [11:0]      epoch_year,
    output logic             done,
    output ycb_pkg::ycb_out_t result
);
    import ycb_pkg::*;

    // stage 0: input register
    logic        v0_reg;
    logic [24:0] secs0_reg;
    logic [7:0]  off0_reg;

    // stage 1: day of year
    logic        v1_reg;
    logic [24:0] secs1_reg;
    logic [8:0]  doy1_reg;
    logic [12:0] year1_reg;

    // stage 2: time of day, month and day
    logic        v2_reg;
    logic [16:0] tod2_reg;
    logic [3:0]  month2_reg;
    logic [4:0]  day2_reg;
    logic        oor2_reg;
    logic [12:0] year2_reg;
    logic [3:0]  yk2_reg;

    // stage 3: minutes of day
    logic        v3_reg;
    logic [16:0] tod3_reg;
    logic [10:0] mins3_reg;
    logic [9:0]  r1_3_reg;
    logic [3:0]  yk3_reg;
    logic [3:0]  month3_reg;
    logic [4:0]  day3_reg;
    logic        oor3_reg;

    // stage 4: hour and second
    logic        v4_reg;
    logic [10:0] mins4_reg;
    logic [4:0]  hour4_reg;
    logic [5:0]  sec4_reg;
    logic [9:0]  r1_4_reg;
    logic [3:0]  yh4_reg;
    logic [3:0]  yk4_reg;
    logic [3:0]  month4_reg;
    logic [4:0]  day4_reg;
    logic        oor4_reg;

    logic     done_reg;
    ycb_out_t result_reg;

    // stage 1 logic
    logic [36:0] doy_prod;
    logic [8:0]  doy1_next;
    logic [12:0] year1_next;

    // stage 2 logic
    logic [25:0] day_base;
    logic [25:0] tod_diff;
    logic        leap;
    logic        oor2_next;
    logic [11:0] below;
    logic [3:0]  month2_next;
    logic [4:0]  day2_next;
    logic [8:0]  mend;
    logic [8:0]  mstart;
    logic [20:0] yk_prod;

    // stage 3 logic
    logic [30:0] mins_prod;
    logic [12:0] r1_diff;

    // stage 4 logic
    logic [16:0] sec_diff;
    logic [18:0] hour_prod;
    logic [16:0] yh_prod;

    // output logic
    logic [10:0] min_diff;
    logic [9:0]  r2_diff;
    ycb_out_t    result_next;

    always_comb
    begin
        doy_prod   = 37'(secs0_reg[24:7]) * 37'(RCP_DAY);
        doy1_next  = doy_prod[36:28];
        year1_next = 13'(epoch_year) + 13'(off0_reg);
    end

    always_comb
    begin
        day_base  = 26'(doy1_reg) * DAY_SECS;
        tod_diff  = 26'(secs1_reg) - day_base;
        leap      = (year1_reg[1:0] == 2'b00);
        oor2_next = (doy1_reg >= YEAR_DAYS + 9'(leap));
        for (int m = 1; m <= 12; m++)
        begin
            mend         = MONTH_START[m] + ((m >= 2) ? 9'(leap) : 9'd0);
            below[m - 1] = (doy1_reg < mend);
        end
        month2_next = '0;
        day2_next   = '0;
        for (int m = 12; m >= 1; m--)
        begin
            mstart = MONTH_START[m - 1] + ((m >= 3) ? 9'(leap) : 9'd0);
            if (below[m - 1] && !oor2_next)
            begin
                month2_next = 4'(m);
                day2_next   = 5'(doy1_reg - mstart + 9'd1);
            end
        end
        yk_prod = 21'(year1_reg[12:3]) * 21'(RCP_THOU);
    end

    always_comb
    begin
        mins_prod = 31'(tod2_reg[16:2]) * 31'(RCP_MIN);
        r1_diff   = year2_reg - 13'(yk2_reg) * 13'd1000;
    end

    always_comb
    begin
        sec_diff  = tod3_reg - 17'(mins3_reg) * 17'd60;
        hour_prod = 19'(mins3_reg[10:2]) * 19'(RCP_HOUR);
        yh_prod   = 17'(r1_3_reg[9:2]) * 17'(RCP_HUND);
    end

    always_comb
    begin
        min_diff = mins4_reg - 11'(hour4_reg) * 11'd60;
        r2_diff  = r1_4_reg - 10'(yh4_reg) * 10'd100;
        result_next.year_bcd     = {yk4_reg, yh4_reg, bcd2(r2_diff[6:0])};
        result_next.month_bcd    = bcd2(7'(month4_reg));
        result_next.day_bcd      = bcd2(7'(day4_reg));
        result_next.hour_bcd     = bcd2(7'(hour4_reg));
        result_next.minute_bcd   = bcd2(min_diff[6:0]);
        result_next.second_bcd   = bcd2(7'(sec4_reg));
        result_next.out_of_range = oor4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= load;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        secs0_reg  <= request.seconds_in_year;
        off0_reg   <= request.year_offset;

        secs1_reg  <= secs0_reg;
        doy1_reg   <= doy1_next;
        year1_reg  <= year1_next;

        tod2_reg   <= tod_diff[16:0];
        month2_reg <= month2_next;
        day2_reg   <= day2_next;
        oor2_reg   <= oor2_next;
        year2_reg  <= year1_reg;
        yk2_reg    <= yk_prod[20:17];

        tod3_reg   <= tod2_reg;
        mins3_reg  <= mins_prod[29:19];
        r1_3_reg   <= r1_diff[9:0];
        yk3_reg    <= yk2_reg;
        month3_reg <= month2_reg;
        day3_reg   <= day2_reg;
        oor3_reg   <= oor2_reg;

        mins4_reg  <= mins3_reg;
        hour4_reg  <= hour_prod[17:13];
        sec4_reg   <= sec_diff[5:0];
        r1_4_reg   <= r1_3_reg;
        yh4_reg    <= yh_prod[16:13];
        yk4_reg    <= yk3_reg;
        month4_reg <= month3_reg;
        day4_reg   <= day3_reg;
        oor4_reg   <= oor3_reg;

        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ##6 done)
        else $error("word did not come out after six cycles");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_of_range |-> result.month_bcd == 8'h00 && result.day_bcd == 8'h00)
        else $error("date fields not cleared past year end");

    a_date_set: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.out_of_range |-> result.month_bcd != 8'h00 && result.day_bcd != 8'h00)
        else $error("missing month or day in range");

    a_time_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.hour_bcd < 8'h24 && result.minute_bcd < 8'h60
                 && result.second_bcd < 8'h60)
        else $error("time of day digits out of range");

endmodule

FILE: src/year_seconds_to_calendar_bcd_top.sv
`timescale 1ns / 1ps

// calendar bcd converter: year offset plus seconds into the year to bcd date and time
// input word: request (year_offset, seconds_in_year), taken at a clock edge where
// start is high and busy is low; busy stays low, so a word can enter every cycle
// output word: result (year, month, day, hour, minute, second bcd, out_of_range),
// held for exactly one cycle while done is high; the receiver cannot stall
// a word taken at a clock edge passes the input, stage 1 to 4 and output registers
// before it shows on result with done high; throughput one word per cycle
// the latency is set by the six register stages around the constant divisions
// (seconds to days, days to month, minutes, hours, year digits)
// leap years use divisible-by-four only; seconds past the year end raise
// out_of_range with month and day at zero, time fields still valid
// configuration: cfg_we with cfg_data writes epoch_year; write it only while idle
// reset: epoch_year returns to 1970 and all words in flight are dropped
module year_seconds_to_calendar_bcd_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ycb_pkg::ycb_in_t  request,
    output logic              done,
    output ycb_pkg::ycb_out_t result,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_data
);
    import ycb_pkg::*;

    logic [11:0] epoch_reg;
    logic [11:0] epoch_next;
    logic        load;

    assign busy = 1'b0;
    assign load = start && !busy;

    always_comb
    begin
        epoch_next = epoch_reg;
        if (cfg_we)
        begin
            epoch_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_RESET;
        end
        else
        begin
            epoch_reg <= epoch_next;
        end
    end

    ycb_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .request    (request),
        .epoch_year (epoch_reg),
        .done       (done),
        .result     (result)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ycb_pkg::*;

    typedef struct packed {
        ycb_in_t  w;
        logic     typed;
        ycb_out_t cal;
    } vec_t;

    localparam int NUM_DIRECTED = 22;

    // year_offset, seconds_in_year, typed, {year, month, day, hour, minute, second, oor}
    localparam vec_t DIRECTED [NUM_DIRECTED] = '{
        {8'd0,   25'd0,        1'b1, 16'h1970, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'd255, 25'd33554431, 1'b1, 16'h2225, 8'h00, 8'h00, 8'h08, 8'h40, 8'h31, 1'b1},
        {8'd0,   25'd31535999, 1'b1, 16'h1970, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59, 1'b0},
        {8'd0,   25'd31536000, 1'b1, 16'h1970, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1},
        {8'd2,   25'd31622399, 1'b1, 16'h1972, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59, 1'b0},
        {8'd2,   25'd31622400, 1'b1, 16'h1972, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1},
        {8'd2,   25'd31536000, 1'b1, 16'h1972, 8'h12, 8'h31, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'd1,   25'd31536000, 1'b1, 16'h1971, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1},
        {8'd0,   25'd86399,    1'b0, 57'd0},
        {8'd0,   25'd86400,    1'b0, 57'd0},
        {8'd0,   25'd2678399,  1'b0, 57'd0},
        {8'd0,   25'd2678400,  1'b0, 57'd0},
        {8'd0,   25'd5097599,  1'b0, 57'd0},
        {8'd0,   25'd5097600,  1'b0, 57'd0},
        {8'd2,   25'd5097600,  1'b0, 57'd0},
        {8'd2,   25'd5183999,  1'b0, 57'd0},
        {8'd2,   25'd5184000,  1'b0, 57'd0},
        {8'd30,  25'd15638400, 1'b0, 57'd0},
        {8'd130, 25'd31622399, 1'b0, 57'd0},
        {8'd128, 25'd16777216, 1'b0, 57'd0},
        {8'd127, 25'd33554431, 1'b0, 57'd0},
        {8'd85,  25'd28857599, 1'b0, 57'd0}
    };

    localparam int NUM_EDGES = 24;
    localparam int EDGE_DAYS [NUM_EDGES] = '{
        0, 31, 59, 60, 90, 91, 120, 121, 151, 152, 181, 182,
        212, 213, 243, 244, 273, 274, 304, 305, 334, 335, 365, 366
    };

    localparam int NUM_PHASES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    ycb_in_t     request = '0;
    logic        done;
    ycb_out_t    result;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_data = '0;

    ycb_out_t    calendar_q [$];
    ycb_out_t    oldest_cal;
    logic [11:0] cur_epoch = EPOCH_RESET;
    int          mismatches = 0;

    year_seconds_to_calendar_bcd_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] two_digits(input int unsigned v);
        return {4'(v / 10 % 10), 4'(v % 10)};
    endfunction

    function automatic ycb_out_t calendar_of(input logic [11:0] epoch, input ycb_in_t w);
        int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int unsigned yr;
        int unsigned leap;
        int unsigned days_left;
        int unsigned tod;
        int unsigned len;
        ycb_out_t    r;
        yr        = int'(epoch) + int'(w.year_offset);
        leap      = (yr % 4 == 0) ? 1 : 0;
        days_left = w.seconds_in_year / 86400;
        tod       = w.seconds_in_year % 86400;
        r         = '0;
        r.year_bcd = {4'(yr / 1000 % 10), 4'(yr / 100 % 10), 4'(yr / 10 % 10), 4'(yr % 10)};
        r.out_of_range = (days_left >= 365 + leap);
        if (!r.out_of_range)
        begin
            for (int m = 0; m < 12; m++)
            begin
                len = month_len[m] + ((m == 1) ? leap : 0);
                if (days_left < len)
                begin
                    r.month_bcd = two_digits(m + 1);
                    r.day_bcd   = two_digits(days_left + 1);
                    break;
                end
                days_left -= len;
            end
        end
        r.hour_bcd   = two_digits(tod / 3600);
        r.minute_bcd = two_digits(tod % 3600 / 60);
        r.second_bcd = two_digits(tod % 60);
        return r;
    endfunction

    function automatic ycb_in_t random_word();
        ycb_in_t     w;
        int unsigned kind;
        int          secs;
        kind          = $urandom_range(0, 99);
        w.year_offset = 8'($urandom_range(0, 255));
        if (kind < 70)
            w.seconds_in_year = 25'($urandom_range(0, 31622399));
        else if (kind < 88)
        begin
            secs = EDGE_DAYS[$urandom_range(0, NUM_EDGES - 1)] * 86400
                   + int'($urandom_range(0, 4)) - 2;
            w.seconds_in_year = (secs < 0) ? 25'd0 : 25'(secs);
        end
        else
            w.seconds_in_year = 25'($urandom);
        return w;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic send_word(input ycb_in_t w, input logic typed, input ycb_out_t cal);
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        calendar_q.push_back(typed ? cal : calendar_of(cur_epoch, w));
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_epoch(input logic [11:0] value);
        start <= 1'b0;
        while (calendar_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_epoch  = value;
    endtask

    // result checker, the receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (calendar_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                oldest_cal = calendar_q.pop_front();
                check_field("year_bcd", oldest_cal.year_bcd, result.year_bcd);
                check_field("month_bcd", 16'(oldest_cal.month_bcd), 16'(result.month_bcd));
                check_field("day_bcd", 16'(oldest_cal.day_bcd), 16'(result.day_bcd));
                check_field("hour_bcd", 16'(oldest_cal.hour_bcd), 16'(result.hour_bcd));
                check_field("minute_bcd", 16'(oldest_cal.minute_bcd),
                            16'(result.minute_bcd));
                check_field("second_bcd", 16'(oldest_cal.second_bcd),
                            16'(result.second_bcd));
                check_field("out_of_range", 16'(oldest_cal.out_of_range),
                            16'(result.out_of_range));
            end
        end
    end

    initial
    begin
        logic [11:0] phase_epoch [NUM_PHASES];
        int          phase_items [NUM_PHASES];
        phase_epoch = '{EPOCH_RESET, 12'd1900, 12'd2099, 12'd0, 12'd4095,
                        12'($urandom_range(1900, 2099)), 12'($urandom_range(1900, 2099)),
                        12'($urandom_range(0, 4095))};
        phase_items = '{350, 350, 350, 150, 150, 200, 200, 200};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if ($urandom_range(0, 99) < 16)
                pause_sender($urandom_range(1, 5));
            send_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].cal);
        end
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
                write_epoch(phase_epoch[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                // phase 2 runs back to back with no gaps
                if (p != 2 && $urandom_range(0, 99) < 16)
                    pause_sender($urandom_range(1, 5));
                send_word(random_word(), 1'b0, '0);
            end
        end
        start <= 1'b0;
        while (calendar_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #200000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
